[src/rmc_pkg.sv]
// Package for the Modbus-RTU reply checker: status and function codes,
// register indexes, the queue entry type and the CRC-16/Modbus byte step.
// Depends on nothing; every other file imports it.
package rmc_pkg;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_CRC       = 3'd2;
  localparam logic [2:0] ST_ADDRESS   = 3'd3;
  localparam logic [2:0] ST_EXCEPTION = 3'd4;
  localparam logic [2:0] ST_FUNCTION  = 3'd5;
  localparam logic [2:0] ST_LENGTH    = 3'd6;

  localparam logic [7:0] FC_READ        = 8'h03;
  localparam logic [7:0] FC_WRITE_ONE   = 8'h06;
  localparam logic [7:0] FC_WRITE_MANY  = 8'h10;
  localparam int         FC_EXC_BIT     = 7;
  localparam logic [7:0] ADDR_BROADCAST = 8'h00;
  localparam logic [7:0] ADDR_ANY       = 8'hFF;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [1:0] REG_DEVICE_ADDRESS     = 2'd0;
  localparam logic [1:0] REG_EXPECTED_FUNCTION  = 2'd1;
  localparam logic [1:0] REG_EXPECTED_REGISTERS = 2'd2;

  typedef struct packed {
    logic        pvalid;
    logic [7:0]  data;
    logic        last;
    logic        short_f;
    logic        rd_len_ok;
    logic        wr_len_ok;
    logic [15:0] rx_crc;
    logic [15:0] run_crc;
    logic [7:0]  addr;
    logic [7:0]  func;
    logic [7:0]  third;
  } rmc_item_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[src/rmc_front.sv]
// Front end of the reply checker: accepts bytes, tracks frame position,
// header bytes, the CRC delay line and the running CRC, and classifies length.
// Depends on rmc_pkg.
module rmc_front
  import rmc_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       in_last_byte,
  input  logic [7:0] expected_function,
  input  logic [6:0] expected_registers,
  input  logic       q_full,
  output logic       q_push,
  output rmc_item_t  q_item
);

  localparam int IDX_W = $clog2(MAX_FRAME_BYTES + 1);

  logic [IDX_W-1:0] idx_r, idx_nxt, len;
  logic [15:0]      crc_r, crc_nxt;
  logic [7:0]       addr_r, addr_nxt;
  logic [7:0]       func_r, func_nxt;
  logic [7:0]       third_r, third_nxt;
  logic [7:0]       d1_r, d1_nxt;
  logic [7:0]       d2_r, d2_nxt;
  logic             take, acc;
  logic [8:0]       idx9, len9, data_end;

  assign in_stall = q_full;
  assign take     = in_valid && !q_full;
  assign q_push   = take;

  always_comb begin
    acc       = idx_r < IDX_W'(MAX_FRAME_BYTES);
    idx9      = 9'(idx_r);
    data_end  = 9'd3 + {1'b0, expected_registers, 1'b0};
    crc_nxt   = (acc && idx9 >= 9'd2) ? crc_feed(crc_r, d2_r) : crc_r;
    d2_nxt    = acc ? d1_r : d2_r;
    d1_nxt    = acc ? in_rx_byte : d1_r;
    addr_nxt  = (acc && idx9 == 9'd0) ? in_rx_byte : addr_r;
    func_nxt  = (acc && idx9 == 9'd1) ? in_rx_byte : func_r;
    third_nxt = (acc && idx9 == 9'd2) ? in_rx_byte : third_r;
    len       = acc ? idx_r + IDX_W'(1) : idx_r;
    idx_nxt   = len;
    len9      = 9'(len);

    q_item.pvalid    = acc && idx9 >= 9'd3 && idx9 < data_end &&
                       func_r == FC_READ && expected_function == FC_READ;
    q_item.data      = in_rx_byte;
    q_item.last      = in_last_byte;
    q_item.short_f   = len9 < 9'd4;
    q_item.rd_len_ok = len9 == data_end + 9'd2;
    q_item.wr_len_ok = len9 == 9'd8;
    q_item.rx_crc    = {d1_nxt, d2_nxt};
    q_item.run_crc   = crc_nxt;
    q_item.addr      = addr_nxt;
    q_item.func      = func_nxt;
    q_item.third     = third_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      crc_r   <= CRC_INIT;
      addr_r  <= '0;
      func_r  <= '0;
      third_r <= '0;
      d1_r    <= '0;
      d2_r    <= '0;
    end else if (take) begin
      if (in_last_byte) begin
        idx_r   <= '0;
        crc_r   <= CRC_INIT;
        addr_r  <= '0;
        func_r  <= '0;
        third_r <= '0;
        d1_r    <= '0;
        d2_r    <= '0;
      end else begin
        idx_r   <= idx_nxt;
        crc_r   <= crc_nxt;
        addr_r  <= addr_nxt;
        func_r  <= func_nxt;
        third_r <= third_nxt;
        d1_r    <= d1_nxt;
        d2_r    <= d2_nxt;
      end
    end
  end

endmodule

[src/rmc_queue.sv]
// Two-entry queue of classified bytes between the front and back ends.
// Depends on rmc_pkg for the entry type.
module rmc_queue
  import rmc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  rmc_item_t push_item,
  input  logic      pop,
  output rmc_item_t head,
  output logic      empty,
  output logic      full
);

  rmc_item_t   mem_r [2];
  logic        wptr_r, rptr_r;
  logic [1:0]  cnt_r;

  assign empty = cnt_r == 2'd0;
  assign full  = cnt_r == 2'd2;
  assign head  = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= ~wptr_r;
      end
      if (pop) begin
        rptr_r <= ~rptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

[src/rmc_back.sv]
// Back end of the reply checker: judges frame status in priority order and
// holds the result transaction in an output register.
// Depends on rmc_pkg.
module rmc_back
  import rmc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  rmc_item_t  head,
  input  logic       q_empty,
  output logic       q_pop,
  input  logic [7:0] device_address,
  input  logic [7:0] expected_function,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_payload_valid,
  output logic [7:0] out_payload_byte,
  output logic       out_frame_done,
  output logic [2:0] out_status,
  output logic [7:0] out_exception_code
);

  logic       valid_r;
  logic       pvalid_r;
  logic [7:0] data_r;
  logic       done_r;
  logic [2:0] status_r, status_nxt;
  logic [7:0] exc_r, exc_nxt;

  assign q_pop = !q_empty && (!valid_r || !out_stall);

  always_comb begin
    status_nxt = ST_OK;
    exc_nxt    = 8'h00;
    if (head.last) begin
      if (head.short_f) begin
        status_nxt = ST_SHORT;
      end else if (head.rx_crc != head.run_crc) begin
        status_nxt = ST_CRC;
      end else if (head.addr != device_address && head.addr != ADDR_BROADCAST &&
                   head.addr != ADDR_ANY) begin
        status_nxt = ST_ADDRESS;
      end else if (head.func[FC_EXC_BIT]) begin
        status_nxt = ST_EXCEPTION;
        exc_nxt    = head.third;
      end else if (head.func != expected_function) begin
        status_nxt = ST_FUNCTION;
      end else if (head.func == FC_READ) begin
        status_nxt = head.rd_len_ok ? ST_OK : ST_LENGTH;
      end else if (head.func == FC_WRITE_ONE || head.func == FC_WRITE_MANY) begin
        status_nxt = head.wr_len_ok ? ST_OK : ST_LENGTH;
      end else begin
        status_nxt = ST_LENGTH;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      pvalid_r <= head.pvalid;
      data_r   <= head.data;
      done_r   <= head.last;
      status_r <= status_nxt;
      exc_r    <= exc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  assign out_valid          = valid_r;
  assign out_payload_valid  = pvalid_r;
  assign out_payload_byte   = data_r;
  assign out_frame_done     = done_r;
  assign out_status         = status_r;
  assign out_exception_code = exc_r;

endmodule

[src/modbus_rtu_response_checker_core.sv]
// Top level of the Modbus-RTU reply checker: configuration registers and the
// front end, queue and back end. Depends on rmc_pkg, rmc_front, rmc_queue, rmc_back.
//
// Usage: reply bytes enter on the in_ channel (in_rx_byte, in_last_byte on
// the final byte), one transaction per byte, accepted when in_valid is high
// and in_stall is low. Each byte yields exactly one result transaction on
// the out_ channel: the byte passed through, its payload flag, frame_done,
// and on the last byte the status and exception code.
// Throughput is one byte per cycle while the receiver does not stall; the unrolled
// eight-bit CRC step of the front end sets the critical loop. Each accepted byte passes
// from the front end into the two-entry queue, then into the output register.
// When the receiver stalls, the output register holds and the queue absorbs
// up to two more bytes before in_stall rises.
// Reset clears the frame state, the queue and the output valid flag and loads
// device_address 1, expected_function 3 and expected_registers 1. The APB
// port (pready always high) holds the three registers at byte addresses
// 0, 4 and 8; write them only while the block is idle.
module modbus_rtu_response_checker_core
  import rmc_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_payload_valid,
  output logic [7:0]  out_payload_byte,
  output logic        out_frame_done,
  output logic [2:0]  out_status,
  output logic [7:0]  out_exception_code,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0] dev_addr_r;
  logic [7:0] exp_func_r;
  logic [6:0] exp_regs_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  rmc_item_t  push_item, head;
  logic       q_push, q_pop, q_empty, q_full;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= 8'd1;
      exp_func_r <= FC_READ;
      exp_regs_r <= 7'd1;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_DEVICE_ADDRESS:     dev_addr_r <= pwdata[7:0];
        REG_EXPECTED_FUNCTION:  exp_func_r <= pwdata[7:0];
        REG_EXPECTED_REGISTERS: exp_regs_r <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DEVICE_ADDRESS:     prdata = {24'd0, dev_addr_r};
      REG_EXPECTED_FUNCTION:  prdata = {24'd0, exp_func_r};
      REG_EXPECTED_REGISTERS: prdata = {25'd0, exp_regs_r};
      default:                prdata = 32'd0;
    endcase
  end

  rmc_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .in_last_byte      (in_last_byte),
    .expected_function (exp_func_r),
    .expected_registers(exp_regs_r),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_item            (push_item)
  );

  rmc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_item(push_item),
    .pop      (q_pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  rmc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (head),
    .q_empty           (q_empty),
    .q_pop             (q_pop),
    .device_address    (dev_addr_r),
    .expected_function (exp_func_r),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_payload_valid (out_payload_valid),
    .out_payload_byte  (out_payload_byte),
    .out_frame_done    (out_frame_done),
    .out_status        (out_status),
    .out_exception_code(out_exception_code)
  );

endmodule

[tb/modbus_rtu_response_checker_core_tb.sv]
// Self-checking testbench for modbus_rtu_response_checker_core: sends reply frames byte by byte
// under random idling and stalls and compares each result with a model of the frame checker.
// Depends on rmc_pkg and the core; registers are programmed through the APB port.
module modbus_rtu_response_checker_core_tb;
  import rmc_pkg::*;

  localparam int FRAME_LIMIT = 256;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    logic       pvalid;
    logic [7:0] pbyte;
    logic       done;
    logic [2:0] status;
    logic [7:0] exc;
  } reply_view_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_payload_valid;
  logic [7:0]  out_payload_byte;
  logic        out_frame_done;
  logic [2:0]  out_status;
  logic [7:0]  out_exception_code;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = 4'h0;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  reply_view_t expected_replies[$];
  reply_view_t want;
  logic [7:0]  frame_buf[$];
  int          mismatch_count = 0;
  int          bytes_sent = 0;
  int          quiet_cycles = 0;
  bit          quiet = 1'b0;

  logic [7:0]  cfg_addr;
  logic [7:0]  cfg_func;
  logic [6:0]  cfg_regs;
  logic [15:0] crc_acc;
  int          frame_len;
  logic [7:0]  addr_b;
  logic [7:0]  func_b;
  logic [7:0]  third_b;
  logic [7:0]  dly1;
  logic [7:0]  dly2;

  modbus_rtu_response_checker_core #(
    .MAX_FRAME_BYTES(FRAME_LIMIT)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_rx_byte(in_rx_byte),
    .in_last_byte(in_last_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_payload_valid(out_payload_valid),
    .out_payload_byte(out_payload_byte),
    .out_frame_done(out_frame_done),
    .out_status(out_status),
    .out_exception_code(out_exception_code),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [15:0] crc16_modbus_step(input logic [15:0] acc, input logic [7:0] d);
    logic [15:0] c;
    int i;
    c = acc;
    for (i = 0; i < 8; i++) begin
      if (c[0] ^ d[i]) begin
        c = {1'b0, c[15:1]} ^ CRC_POLY;
      end else begin
        c = {1'b0, c[15:1]};
      end
    end
    return c;
  endfunction

  task automatic note_mismatch();
    mismatch_count++;
  endtask

  task automatic clear_frame_model();
    crc_acc = CRC_INIT;
    frame_len = 0;
    addr_b = 8'h00;
    func_b = 8'h00;
    third_b = 8'h00;
    dly1 = 8'h00;
    dly2 = 8'h00;
  endtask

  task automatic model_accept_byte(input logic [7:0] b, input logic last);
    reply_view_t r;
    int data_end;
    logic [15:0] rx_crc;
    r = '0;
    r.pbyte = b;
    r.done = last;
    data_end = 3 + 2 * int'(cfg_regs);
    if (frame_len < FRAME_LIMIT) begin
      if (frame_len == 0) begin
        addr_b = b;
      end else if (frame_len == 1) begin
        func_b = b;
      end else if (frame_len == 2) begin
        third_b = b;
      end
      if (frame_len >= 3 && frame_len < data_end && func_b == FC_READ && cfg_func == FC_READ) begin
        r.pvalid = 1'b1;
      end
      if (frame_len >= 2) begin
        crc_acc = crc16_modbus_step(crc_acc, dly2);
      end
      dly2 = dly1;
      dly1 = b;
      frame_len++;
    end
    if (last) begin
      rx_crc = {dly1, dly2};
      if (frame_len < 4) begin
        r.status = ST_SHORT;
      end else if (rx_crc != crc_acc) begin
        r.status = ST_CRC;
      end else if (addr_b != cfg_addr && addr_b != ADDR_BROADCAST && addr_b != ADDR_ANY) begin
        r.status = ST_ADDRESS;
      end else if (func_b[FC_EXC_BIT]) begin
        r.status = ST_EXCEPTION;
        r.exc = third_b;
      end else if (func_b != cfg_func) begin
        r.status = ST_FUNCTION;
      end else if (func_b == FC_READ) begin
        r.status = (frame_len == data_end + 2) ? ST_OK : ST_LENGTH;
      end else if (func_b == FC_WRITE_ONE || func_b == FC_WRITE_MANY) begin
        r.status = (frame_len == 8) ? ST_OK : ST_LENGTH;
      end else begin
        r.status = ST_LENGTH;
      end
      clear_frame_model();
    end
    expected_replies.push_back(r);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (!quiet) begin
      while ($urandom_range(99) < 18) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    model_accept_byte(b, last);
    bytes_sent++;
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_replies.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic send_frame(input int pause_at);
    int i;
    for (i = 0; i < frame_buf.size(); i++) begin
      if (i == pause_at) begin
        wait_drain();
      end
      send_byte(frame_buf[i], i == frame_buf.size() - 1);
    end
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [7:0] val);
    logic [31:0] stored;
    stored = (idx == REG_EXPECTED_REGISTERS) ? {25'd0, val[6:0]} : {24'd0, val};
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'($urandom()), val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_DEVICE_ADDRESS: cfg_addr = stored[7:0];
      REG_EXPECTED_FUNCTION: cfg_func = stored[7:0];
      default: cfg_regs = stored[6:0];
    endcase
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== stored) begin
      note_mismatch();
      if (mismatch_count <= 10) begin
        $display("register %0d readback: expected %h, got %h", idx, stored, prdata);
      end
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_config(input logic [7:0] a, input logic [7:0] f, input logic [6:0] n);
    wait_drain();
    repeat (3) @(posedge clk);
    cfg_write(REG_DEVICE_ADDRESS, a);
    cfg_write(REG_EXPECTED_FUNCTION, f);
    cfg_write(REG_EXPECTED_REGISTERS, {1'($urandom()), n});
  endtask

  task automatic append_crc();
    logic [15:0] c;
    int i;
    c = CRC_INIT;
    for (i = 0; i < frame_buf.size(); i++) begin
      c = crc16_modbus_step(c, frame_buf[i]);
    end
    frame_buf.push_back(c[7:0]);
    frame_buf.push_back(c[15:8]);
  endtask

  task automatic push_random(input int count);
    int i;
    for (i = 0; i < count; i++) begin
      frame_buf.push_back(8'($urandom()));
    end
  endtask

  function automatic logic [7:0] pick_address();
    int r;
    r = $urandom_range(9);
    if (r < 6) begin
      return cfg_addr;
    end else if (r == 6) begin
      return ADDR_BROADCAST;
    end else if (r == 7) begin
      return ADDR_ANY;
    end
    return 8'($urandom());
  endfunction

  task automatic build_body(input logic [7:0] a, input logic [7:0] f);
    frame_buf.push_back(a);
    frame_buf.push_back(f);
    if (f == FC_READ) begin
      frame_buf.push_back(8'(2 * int'(cfg_regs)));
      push_random(2 * int'(cfg_regs));
    end else if (f == FC_WRITE_ONE || f == FC_WRITE_MANY) begin
      push_random(4);
    end else begin
      push_random($urandom_range(6));
    end
  endtask

  task automatic build_random_frame();
    int kind;
    int pos;
    logic [7:0] f;
    kind = $urandom_range(99);
    frame_buf.delete();
    if (kind < 60) begin
      build_body(pick_address(), cfg_func);
      if (kind >= 40 && kind < 50) begin
        if ($urandom_range(1) && frame_buf.size() > 2) begin
          void'(frame_buf.pop_back());
        end else begin
          push_random($urandom_range(1, 2));
        end
      end
      append_crc();
      if (kind >= 50) begin
        pos = $urandom_range(frame_buf.size() - 1);
        frame_buf[pos] = frame_buf[pos] ^ (8'h01 << $urandom_range(7));
      end
    end else if (kind < 68) begin
      frame_buf.push_back(pick_address());
      frame_buf.push_back(8'($urandom()) | 8'h80);
      push_random(1);
      append_crc();
    end else if (kind < 76) begin
      build_body(8'($urandom()), cfg_func);
      append_crc();
    end else if (kind < 84) begin
      case ($urandom_range(3))
        0: f = FC_READ;
        1: f = FC_WRITE_ONE;
        2: f = FC_WRITE_MANY;
        default: f = 8'($urandom());
      endcase
      build_body(pick_address(), f);
      append_crc();
    end else if (kind < 90) begin
      push_random($urandom_range(1, 3));
    end else begin
      push_random($urandom_range(1, 12));
      if ($urandom_range(1)) begin
        append_crc();
      end
    end
  endtask

  task automatic test_short_frame();
    frame_buf = '{8'h01, FC_READ};
    send_frame(-1);
    frame_buf = '{8'hFF};
    send_frame(-1);
  endtask

  task automatic test_read_reply();
    frame_buf = '{8'h01, FC_READ, 8'h02, 8'h00, 8'hFF};
    append_crc();
    send_frame(3);
  endtask

  task automatic test_exception_reply();
    frame_buf = '{8'h01, FC_READ | 8'h80, 8'h02};
    append_crc();
    send_frame(-1);
  endtask

  task automatic test_write_reply();
    apply_config(8'h01, FC_WRITE_ONE, 7'd1);
    frame_buf = '{ADDR_ANY, FC_WRITE_ONE, 8'h00, 8'h01, 8'hAB, 8'hCD};
    append_crc();
    send_frame(-1);
  endtask

  task automatic test_zero_register_count();
    apply_config(8'h00, FC_READ, 7'd0);
    frame_buf = '{8'h00, FC_READ, 8'h00};
    append_crc();
    send_frame(-1);
  endtask

  task automatic test_overlong_frames();
    apply_config(8'h01, FC_WRITE_MANY, 7'd1);
    frame_buf.delete();
    frame_buf.push_back(8'h01);
    frame_buf.push_back(FC_WRITE_MANY);
    push_random(FRAME_LIMIT - 4);
    append_crc();
    push_random(3);
    send_frame(-1);
    frame_buf.delete();
    push_random(FRAME_LIMIT + 6);
    send_frame(-1);
  endtask

  task automatic test_random_frames();
    int phase;
    int budget_end;
    logic [7:0] a;
    logic [7:0] f;
    logic [6:0] n;
    for (phase = 0; phase < 12; phase++) begin
      a = 8'($urandom());
      n = 7'($urandom_range(1, 8));
      case ($urandom_range(3))
        0: f = FC_READ;
        1: f = FC_WRITE_ONE;
        2: f = FC_WRITE_MANY;
        default: f = 8'($urandom());
      endcase
      case (phase)
        0: begin a = 8'h01; f = FC_READ; n = 7'd1; end
        1: begin a = 8'h00; f = FC_READ; n = 7'd125; end
        2: begin a = 8'hFF; f = FC_WRITE_ONE; end
        3: f = FC_WRITE_MANY;
        4: begin f = 8'($urandom()); n = 7'd127; end
        5: begin f = FC_READ; n = 7'd0; end
        6: f = FC_READ;
        7: begin f = FC_READ; n = 7'd126; end
        default: ;
      endcase
      apply_config(a, f, n);
      quiet = (phase == 5);
      budget_end = bytes_sent + 70;
      while (bytes_sent < budget_end) begin
        build_random_frame();
        send_frame(($urandom_range(49) == 0) ? int'($urandom_range(frame_buf.size() - 1)) : -1);
      end
      quiet = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_replies.size() == 0) begin
        note_mismatch();
        if (mismatch_count <= 10) begin
          $display("result transaction with nothing expected: byte %h done %b status %0d",
                   out_payload_byte, out_frame_done, out_status);
        end
      end else begin
        want = expected_replies.pop_front();
        if (out_payload_valid !== want.pvalid || out_payload_byte !== want.pbyte ||
            out_frame_done !== want.done || out_status !== want.status ||
            out_exception_code !== want.exc) begin
          note_mismatch();
          if (mismatch_count <= 10) begin
            $display("mismatch: expected pv %b byte %h done %b status %0d exc %h",
                     want.pvalid, want.pbyte, want.done, want.status, want.exc);
            $display("          actual   pv %b byte %h done %b status %0d exc %h",
                     out_payload_valid, out_payload_byte, out_frame_done, out_status,
                     out_exception_code);
          end
        end
      end
    end
    out_stall <= !quiet && ($urandom_range(99) < 18);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    cfg_addr = 8'h01;
    cfg_func = FC_READ;
    cfg_regs = 7'd1;
    clear_frame_model();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_short_frame();
    test_read_reply();
    test_exception_reply();
    test_write_reply();
    test_zero_register_count();
    test_overlong_frames();
    test_random_frames();
    wait_drain();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_replies.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[files.f]
src/rmc_pkg.sv
src/rmc_front.sv
src/rmc_queue.sv
src/rmc_back.sv
src/modbus_rtu_response_checker_core.sv
tb/modbus_rtu_response_checker_core_tb.sv
